>>> src/bwt_pkg.sv
// Shared types and constants of the Burrows-Wheeler transform block.
`default_nettype none
package bwt_pkg;

  // Default text capacity in bytes.
  localparam int MAX_LEN_DEF = 1024;

  // Stream widths: slave tdata holds data_byte and read_index, master tdata
  // holds status and out_byte, both padded to whole bytes.
  localparam int S_TDATA_W = 24;
  localparam int M_TDATA_W = 16;
  localparam int IDX_W     = 10;

  // Operation codes carried on s_tuser.
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_READ   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_ERR = 2'd2;

  // Sequencer states; the datapath executes the step named by the state.
  typedef enum logic [4:0] {
    S_IDLE,
    S_DECODE,
    S_APPEND,
    S_CLR,
    S_H_RD, S_H_CNT, S_H_WR,
    S_P_RD, S_P_WR,
    S_S_RD, S_S_CNT, S_S_WR,
    S_K_RD, S_K_T, S_K_WR,
    S_D_RD, S_D_C, S_D_B, S_D_WR,
    S_Y_RD, S_Y_WR,
    S_R_RD, S_R_C1, S_R_C2, S_R_WR,
    S_Z_RD, S_Z_WR,
    S_DONE_T,
    S_READ_A, S_READ_B, S_READ_C,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    state_t step;
    logic   in_ready;
    logic   out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic accept;
    logic op;
    logic last;
    logic rd_err;
    logic i_last;
    logic v_last;
    logic more_k;
    logic more_z;
    logic out_busy;
  } stat_t;

endpackage
`default_nettype wire

>>> src/bwt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> src/bwt_ctrl.sv
// Sequencer for loading, sorting rotations and reading the transform.
`default_nettype none
module bwt_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire bwt_pkg::stat_t st,
  output bwt_pkg::cmd_t       cmd
);

  bwt_pkg::state_t state, state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bwt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      // An accepted beat leaves the idle state.
      bwt_pkg::S_IDLE:   state_next = st.accept ? bwt_pkg::S_DECODE : bwt_pkg::S_IDLE;
      bwt_pkg::S_DECODE: begin
        state_next = (st.op == bwt_pkg::OP_APPEND) ? bwt_pkg::S_APPEND : bwt_pkg::S_READ_A;
      end
      bwt_pkg::S_APPEND: state_next = st.last ? bwt_pkg::S_CLR : bwt_pkg::S_FINISH;
      bwt_pkg::S_CLR:    state_next = st.v_last ? bwt_pkg::S_H_RD : bwt_pkg::S_CLR;
      bwt_pkg::S_H_RD:   state_next = bwt_pkg::S_H_CNT;
      bwt_pkg::S_H_CNT:  state_next = bwt_pkg::S_H_WR;
      bwt_pkg::S_H_WR:   state_next = st.i_last ? bwt_pkg::S_P_RD : bwt_pkg::S_H_RD;
      bwt_pkg::S_P_RD:   state_next = bwt_pkg::S_P_WR;
      bwt_pkg::S_P_WR:   state_next = st.v_last ? bwt_pkg::S_S_RD : bwt_pkg::S_P_RD;
      bwt_pkg::S_S_RD:   state_next = bwt_pkg::S_S_CNT;
      bwt_pkg::S_S_CNT:  state_next = bwt_pkg::S_S_WR;
      bwt_pkg::S_S_WR:   state_next = st.i_last ? bwt_pkg::S_K_RD : bwt_pkg::S_S_RD;
      bwt_pkg::S_K_RD:   state_next = bwt_pkg::S_K_T;
      bwt_pkg::S_K_T:    state_next = bwt_pkg::S_K_WR;
      bwt_pkg::S_K_WR: begin
        if (!st.i_last) begin
          state_next = bwt_pkg::S_K_RD;
        end else begin
          state_next = st.more_k ? bwt_pkg::S_D_RD : bwt_pkg::S_DONE_T;
        end
      end
      bwt_pkg::S_D_RD:   state_next = bwt_pkg::S_D_C;
      bwt_pkg::S_D_C:    state_next = bwt_pkg::S_D_B;
      bwt_pkg::S_D_B:    state_next = bwt_pkg::S_D_WR;
      bwt_pkg::S_D_WR:   state_next = st.i_last ? bwt_pkg::S_Y_RD : bwt_pkg::S_D_RD;
      bwt_pkg::S_Y_RD:   state_next = bwt_pkg::S_Y_WR;
      bwt_pkg::S_Y_WR:   state_next = st.i_last ? bwt_pkg::S_R_RD : bwt_pkg::S_Y_RD;
      bwt_pkg::S_R_RD:   state_next = bwt_pkg::S_R_C1;
      bwt_pkg::S_R_C1:   state_next = bwt_pkg::S_R_C2;
      bwt_pkg::S_R_C2:   state_next = bwt_pkg::S_R_WR;
      bwt_pkg::S_R_WR:   state_next = st.i_last ? bwt_pkg::S_Z_RD : bwt_pkg::S_R_RD;
      bwt_pkg::S_Z_RD:   state_next = bwt_pkg::S_Z_WR;
      bwt_pkg::S_Z_WR: begin
        if (!st.i_last) begin
          state_next = bwt_pkg::S_Z_RD;
        end else begin
          state_next = st.more_z ? bwt_pkg::S_D_RD : bwt_pkg::S_DONE_T;
        end
      end
      bwt_pkg::S_DONE_T: state_next = bwt_pkg::S_FINISH;
      bwt_pkg::S_READ_A: state_next = st.rd_err ? bwt_pkg::S_FINISH : bwt_pkg::S_READ_B;
      bwt_pkg::S_READ_B: state_next = bwt_pkg::S_READ_C;
      bwt_pkg::S_READ_C: state_next = bwt_pkg::S_FINISH;
      bwt_pkg::S_FINISH: state_next = st.out_busy ? bwt_pkg::S_FINISH : bwt_pkg::S_IDLE;
      default:           state_next = bwt_pkg::S_IDLE;
    endcase
  end

  // Command outputs.
  always_comb begin
    cmd.step     = state;
    cmd.in_ready = 1'b0;
    cmd.out_load = 1'b0;
    case (state)
      bwt_pkg::S_IDLE:   cmd.in_ready = 1'b1;
      bwt_pkg::S_FINISH: cmd.out_load = !st.out_busy;
      default:           cmd.out_load = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

>>> src/bwt_dp.sv
// Datapath: text and sort memories, loop counters and the result register.
`default_nettype none
module bwt_dp #(
  parameter int MAX_LEN = bwt_pkg::MAX_LEN_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bwt_pkg::cmd_t                   cmd,
  output bwt_pkg::stat_t                       st,
  input  wire logic                            s_tvalid,
  input  wire logic [bwt_pkg::S_TDATA_W-1:0]   s_tdata,
  input  wire logic                            s_tuser,
  input  wire logic                            s_tlast,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [bwt_pkg::M_TDATA_W-1:0]   m_tdata,
  output logic                                 accept_pulse
);

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int CMP_W  = (LEN_W > bwt_pkg::IDX_W) ? LEN_W : bwt_pkg::IDX_W;
  localparam logic [LEN_W-1:0] MAX_L = LEN_W'(MAX_LEN);

  // Captured item fields.
  logic                      op, last;
  logic [7:0]                din;
  logic [bwt_pkg::IDX_W-1:0] idx;

  // Control registers and loop state.
  logic [LEN_W-1:0]  tl, len, s;
  logic              done;
  logic [ADDR_W-1:0] i, cls, preg, jreg, breg, c1reg, pc1, pc2;
  logic [7:0]        v, tb, prevb;
  logic [1:0]        res_status;
  logic [7:0]        res_byte;

  // Memory ports.
  logic              t_we, o_we, c_we, b_we, no_we, nc_we, k_we;
  logic [ADDR_W-1:0] t_wa, t_ra, o_wa, o_ra, c_wa, c_ra, b_wa, b_ra;
  logic [ADDR_W-1:0] no_wa, no_ra, nc_wa, nc_ra;
  logic [7:0]        k_wa, k_ra, t_wd, t_rd;
  logic [ADDR_W-1:0] o_wd, o_rd, c_wd, c_rd, no_wd, no_rd, nc_wd, nc_rd;
  logic [LEN_W-1:0]  b_wd, b_rd, k_wd, k_rd;

  // Derived values.
  logic              accept, fresh_k, fresh_r;
  logic [LEN_W-1:0]  le, pe, je, slot, q;
  logic [LEN_W:0]    wsum, len2;
  logic [ADDR_W-1:0] clsk, clsr, pwrap;
  logic [CMP_W-1:0]  idx_ext;

  assign accept       = s_tvalid && cmd.in_ready;
  assign accept_pulse = accept;
  assign le           = done ? '0 : tl;
  assign idx_ext      = CMP_W'(idx);
  assign pe           = LEN_W'(o_rd);
  assign je           = (pe >= len) ? pe - len : pe + tl - len;
  assign wsum         = {1'b0, LEN_W'(preg)} + {1'b0, len};
  assign pwrap        = (wsum >= {1'b0, tl}) ? ADDR_W'(wsum - {1'b0, tl}) : ADDR_W'(wsum);
  assign slot         = (b_rd >= tl) ? b_rd - tl : b_rd;
  assign q            = (pe == '0) ? tl - 1'b1 : pe - 1'b1;
  assign len2         = {len, 1'b0};
  assign fresh_k      = (i == '0) || (t_rd != prevb);
  assign fresh_r      = (i == '0) || (c1reg != pc1) || (c_rd != pc2);
  assign clsk         = (i == '0) ? '0 : cls + ADDR_W'(fresh_k);
  assign clsr         = (i == '0) ? '0 : cls + ADDR_W'(fresh_r);

  // Status toward the controller.
  always_comb begin
    st.accept   = accept;
    st.op       = op;
    st.last     = last;
    st.rd_err   = !done || (idx_ext >= CMP_W'(tl));
    st.i_last   = (LEN_W'(i) + 1'b1) == tl;
    st.v_last   = (v == 8'hff);
    st.more_k   = tl > LEN_W'(1);
    st.more_z   = len2 < {1'b0, tl};
    st.out_busy = m_tvalid && !m_tready;
  end

  // Memory addressing and write data per step.
  always_comb begin
    t_we = 1'b0; t_wa = ADDR_W'(le); t_wd = din; t_ra = i;
    k_we = 1'b0; k_wa = tb; k_wd = k_rd + 1'b1; k_ra = t_rd;
    o_we = 1'b0; o_wa = ADDR_W'(k_rd); o_wd = i; o_ra = i;
    c_we = 1'b0; c_wa = preg; c_wd = clsk; c_ra = ADDR_W'(je);
    b_we = 1'b0; b_wa = clsk; b_wd = LEN_W'(i); b_ra = c_rd;
    no_we = 1'b0; no_wa = ADDR_W'(slot); no_wd = jreg; no_ra = i;
    nc_we = 1'b0; nc_wa = preg; nc_wd = clsr; nc_ra = i;
    case (cmd.step)
      bwt_pkg::S_APPEND: t_we = (le < MAX_L);
      bwt_pkg::S_CLR: begin
        k_we = 1'b1; k_wa = v; k_wd = '0;
      end
      bwt_pkg::S_H_WR:  k_we = 1'b1;
      bwt_pkg::S_P_RD:  k_ra = v;
      bwt_pkg::S_P_WR: begin
        k_we = 1'b1; k_wa = v; k_wd = s;
      end
      bwt_pkg::S_S_WR: begin
        k_we = 1'b1; o_we = 1'b1;
      end
      bwt_pkg::S_K_T:   t_ra = o_rd;
      bwt_pkg::S_K_WR: begin
        c_we = 1'b1; b_we = fresh_k;
      end
      bwt_pkg::S_D_WR: begin
        no_we = 1'b1; b_we = 1'b1; b_wa = breg; b_wd = slot + 1'b1;
      end
      bwt_pkg::S_Y_WR: begin
        o_we = 1'b1; o_wa = i; o_wd = no_rd;
      end
      bwt_pkg::S_R_C1:  c_ra = o_rd;
      bwt_pkg::S_R_C2:  c_ra = pwrap;
      bwt_pkg::S_R_WR: begin
        nc_we = 1'b1; b_we = fresh_r; b_wa = clsr;
      end
      bwt_pkg::S_Z_WR: begin
        c_we = 1'b1; c_wa = i; c_wd = nc_rd;
      end
      bwt_pkg::S_READ_A: o_ra = idx_ext[ADDR_W-1:0];
      bwt_pkg::S_READ_B: t_ra = ADDR_W'(q);
      default: t_we = 1'b0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tl   <= '0;
      done <= 1'b0;
    end else begin
      case (cmd.step)
        bwt_pkg::S_APPEND: begin
          done <= 1'b0;
          tl   <= (le < MAX_L) ? le + 1'b1 : le;
        end
        bwt_pkg::S_DONE_T: done <= 1'b1;
        default:           done <= done;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {{(bwt_pkg::M_TDATA_W - 10){1'b0}}, res_byte, res_status};
    end
  end

  // Item capture, loop counters and working registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= s_tuser;
      last <= s_tlast;
      din  <= s_tdata[7:0];
      idx  <= s_tdata[17:8];
      i    <= '0;
      v    <= '0;
      s    <= '0;
    end
    case (cmd.step)
      bwt_pkg::S_APPEND: begin
        res_status <= (le < MAX_L) ? bwt_pkg::ST_OK : bwt_pkg::ST_OVF;
        res_byte   <= '0;
      end
      bwt_pkg::S_CLR:    v <= v + 1'b1;
      bwt_pkg::S_H_CNT:  tb <= t_rd;
      bwt_pkg::S_S_CNT:  tb <= t_rd;
      bwt_pkg::S_P_WR: begin
        v <= v + 1'b1;
        s <= s + k_rd;
      end
      bwt_pkg::S_K_T:    preg <= o_rd;
      bwt_pkg::S_K_WR: begin
        cls   <= clsk;
        prevb <= t_rd;
        len   <= LEN_W'(1);
      end
      bwt_pkg::S_D_C:    jreg <= ADDR_W'(je);
      bwt_pkg::S_D_B:    breg <= c_rd;
      bwt_pkg::S_R_C1:   preg <= o_rd;
      bwt_pkg::S_R_C2:   c1reg <= c_rd;
      bwt_pkg::S_R_WR: begin
        cls <= clsr;
        pc1 <= c1reg;
        pc2 <= c_rd;
      end
      bwt_pkg::S_Z_WR: begin
        if (st.i_last) begin
          len <= len2[LEN_W-1:0];
        end
      end
      bwt_pkg::S_READ_A: begin
        res_status <= st.rd_err ? bwt_pkg::ST_ERR : bwt_pkg::ST_OK;
        res_byte   <= '0;
      end
      bwt_pkg::S_READ_C: res_byte <= t_rd;
      default: tb <= tb;
    endcase
    // Element counter shared by every pass over the text.
    if (cmd.step == bwt_pkg::S_H_WR || cmd.step == bwt_pkg::S_S_WR ||
        cmd.step == bwt_pkg::S_K_WR || cmd.step == bwt_pkg::S_D_WR ||
        cmd.step == bwt_pkg::S_Y_WR || cmd.step == bwt_pkg::S_R_WR ||
        cmd.step == bwt_pkg::S_Z_WR) begin
      i <= st.i_last ? '0 : i + 1'b1;
    end
  end

  // Memories.
  bwt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk(clk), .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  bwt_ram #(.WIDTH(LEN_W), .DEPTH(256)) u_count (
    .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd)
  );
  bwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_order (
    .clk(clk), .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd)
  );
  bwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_class (
    .clk(clk), .we(c_we), .waddr(c_wa), .wdata(c_wd), .raddr(c_ra), .rdata(c_rd)
  );
  bwt_ram #(.WIDTH(LEN_W), .DEPTH(MAX_LEN)) u_bucket (
    .clk(clk), .we(b_we), .waddr(b_wa), .wdata(b_wd), .raddr(b_ra), .rdata(b_rd)
  );
  bwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_next_order (
    .clk(clk), .we(no_we), .waddr(no_wa), .wdata(no_wd), .raddr(no_ra), .rdata(no_rd)
  );
  bwt_ram #(.WIDTH(ADDR_W), .DEPTH(MAX_LEN)) u_next_class (
    .clk(clk), .we(nc_we), .waddr(nc_wa), .wdata(nc_wd), .raddr(nc_ra), .rdata(nc_rd)
  );

endmodule
`default_nettype wire

>>> src/burrows_wheeler_transform.sv
// Each item runs through the decode state and then its own states to the finish state,
// which loads the output register; a failed read skips the order and text reads.
// An append that ends the text also runs the sort of all rotations, paced by the
// one-access-per-cycle sort memories.
// One item is in work at a time; the output register holds a result while
// the next beat is taken. Reset clears the text length and the done flag.
`default_nettype none
module burrows_wheeler_transform #(
  parameter int MAX_LEN = bwt_pkg::MAX_LEN_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [bwt_pkg::S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], read_index[17:8]
  input  wire logic                          s_tuser,  // operation
  input  wire logic                          s_tlast,  // is_last
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic      [bwt_pkg::M_TDATA_W-1:0] m_tdata   // status[1:0], out_byte[9:2]
);

  bwt_pkg::cmd_t  cmd;
  bwt_pkg::stat_t st;
  logic           accept_pulse;

  assign s_tready = cmd.in_ready;

  // Sequencer.
  bwt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .st(st), .cmd(cmd)
  );

  // Datapath.
  bwt_dp #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .st(st),
    .s_tvalid(s_tvalid), .s_tdata(s_tdata), .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .accept_pulse(accept_pulse)
  );

`ifndef ASSERT_OFF
  // Only one item is in work: an accepted beat drops ready for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    accept_pulse |=> !s_tready) else $error("beat taken while busy");

  // A failed item never carries a byte.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != bwt_pkg::ST_OK) |-> (m_tdata[9:2] == 8'd0))
    else $error("nonzero byte on error result");

  // The status code is always a defined one.
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == bwt_pkg::ST_OK || m_tdata[1:0] == bwt_pkg::ST_OVF ||
                  m_tdata[1:0] == bwt_pkg::ST_ERR)) else $error("bad status code");
`endif

endmodule
`default_nettype wire
